// ===== rtl/core/wbrl_pkg.sv =====
// Types and constants shared by the write buffer rate limiter modules.
package wbrl_pkg;

   // Window size of one user request, as a power of two
   localparam int REQ_WINDOW_LOG2 = 6;

   // Width of the reported free user block count
   localparam int FREE_OUT_BITS = 20;

   // Saturation value of the occupancy counters
   localparam logic [15:0] CNT_MAX = 16'hFFFF;
   localparam logic [7:0]  ERR_LINES_MAX = 8'hFF;

   // Event kinds
   localparam logic [3:0] KIND_CHECK      = 4'd0;
   localparam logic [3:0] KIND_USER_IN    = 4'd1;
   localparam logic [3:0] KIND_GC_IN      = 4'd2;
   localparam logic [3:0] KIND_COMPLETE   = 4'd3;
   localparam logic [3:0] KIND_INSERTED   = 4'd4;
   localparam logic [3:0] KIND_WERR_IN    = 4'd5;
   localparam logic [3:0] KIND_WERR_OUT   = 4'd6;
   localparam logic [3:0] KIND_LINE_FREED = 4'd7;
   localparam logic [3:0] KIND_LINE_TAKEN = 4'd8;
   localparam logic [3:0] KIND_RECOMPUTE  = 4'd9;
   localparam logic [3:0] KIND_TICK       = 4'd10;

   // User verdicts
   localparam logic [1:0] VERDICT_OK      = 2'd0;
   localparam logic [1:0] VERDICT_REQUEUE = 2'd1;
   localparam logic [1:0] VERDICT_ERROR   = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_BUDGET      = 3'd0;
   localparam logic [2:0] REG_HIGH_THR    = 3'd1;
   localparam logic [2:0] REG_HIGH_LOG2   = 3'd2;
   localparam logic [2:0] REG_WIN_LOG2    = 3'd3;
   localparam logic [2:0] REG_RESERVE     = 3'd4;
   localparam logic [2:0] REG_SPACE_LIMIT = 3'd5;
   localparam logic [2:0] REG_IDLE_TMO    = 3'd6;

   // Register reset values
   localparam logic [15:0] BUDGET_RST      = 16'd4096;
   localparam logic [19:0] HIGH_THR_RST    = 20'd1024;
   localparam logic [4:0]  HIGH_LOG2_RST   = 5'd10;
   localparam logic [3:0]  WIN_LOG2_RST    = 4'd6;
   localparam logic [19:0] RESERVE_RST     = 20'd64;
   localparam logic [16:0] SPACE_LIMIT_RST = 17'h1FFFF;
   localparam logic [15:0] IDLE_TMO_RST    = 16'd5000;

   typedef enum logic [1:0] {
      RATE_INIT = 2'd0,
      RATE_OFF  = 2'd1,
      RATE_WERR = 2'd2,
      RATE_LOW  = 2'd3
   } rate_state_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] count_a;
      logic [15:0] count_b;
      logic        line_used;
   } req_type;

   typedef struct packed {
      logic [1:0]  user_verdict;
      logic        gc_allowed;
      logic        buffer_full;
      logic [1:0]  rate_state;
      logic [15:0] user_limit;
      logic [15:0] gc_limit;
      logic        gc_should_run;
      logic [19:0] free_user_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] budget;
      logic [19:0] high_thr;
      logic [4:0]  high_log2;
      logic [3:0]  win_log2;
      logic [19:0] reserve;
      logic [16:0] space_limit;
      logic [15:0] idle_tmo;
   } cfg_type;

   // Register writes that also load state
   typedef struct packed {
      logic        budget_load;
      logic [15:0] budget_val;
      logic        space_load;
      logic        space_unl;
      logic [15:0] space_val;
   } cfg_load_type;

   typedef struct packed {
      logic [15:0]    user_cap;
      logic [15:0]    gc_max;
      rate_state_type state;
   } rate_type;

endpackage

// ===== rtl/core/wbrl_csr.sv =====
// Configuration register file behind the APB-style port.
module wbrl_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output wbrl_pkg::cfg_type     cfg,
   output wbrl_pkg::cfg_load_type load
);

   wbrl_pkg::cfg_type cfg_ff;
   wbrl_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        index;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = paddr[4:2];
   assign cfg    = cfg_ff;

   // Decode the write word into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      load   = '0;
      load.budget_val = pwdata[15:0];
      load.space_unl  = pwdata[16];
      load.space_val  = pwdata[15:0];
      if (wr_en) begin
         case (index)
            wbrl_pkg::REG_BUDGET: begin
               cfg_in.budget    = pwdata[15:0];
               load.budget_load = 1'b1;
            end
            wbrl_pkg::REG_HIGH_THR:  cfg_in.high_thr  = pwdata[19:0];
            wbrl_pkg::REG_HIGH_LOG2: cfg_in.high_log2 = pwdata[4:0];
            wbrl_pkg::REG_WIN_LOG2:  cfg_in.win_log2  = pwdata[3:0];
            wbrl_pkg::REG_RESERVE:   cfg_in.reserve   = pwdata[19:0];
            wbrl_pkg::REG_SPACE_LIMIT: begin
               // any negative value means unlimited, kept as all ones
               cfg_in.space_limit = pwdata[16] ? wbrl_pkg::SPACE_LIMIT_RST : pwdata[16:0];
               load.space_load    = 1'b1;
            end
            wbrl_pkg::REG_IDLE_TMO:  cfg_in.idle_tmo  = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.budget      <= wbrl_pkg::BUDGET_RST;
         cfg_ff.high_thr    <= wbrl_pkg::HIGH_THR_RST;
         cfg_ff.high_log2   <= wbrl_pkg::HIGH_LOG2_RST;
         cfg_ff.win_log2    <= wbrl_pkg::WIN_LOG2_RST;
         cfg_ff.reserve     <= wbrl_pkg::RESERVE_RST;
         cfg_ff.space_limit <= wbrl_pkg::SPACE_LIMIT_RST;
         cfg_ff.idle_tmo    <= wbrl_pkg::IDLE_TMO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (index)
         wbrl_pkg::REG_BUDGET:      prdata = 32'(cfg_ff.budget);
         wbrl_pkg::REG_HIGH_THR:    prdata = 32'(cfg_ff.high_thr);
         wbrl_pkg::REG_HIGH_LOG2:   prdata = 32'(cfg_ff.high_log2);
         wbrl_pkg::REG_WIN_LOG2:    prdata = 32'(cfg_ff.win_log2);
         wbrl_pkg::REG_RESERVE:     prdata = 32'(cfg_ff.reserve);
         wbrl_pkg::REG_SPACE_LIMIT: prdata = 32'(cfg_ff.space_limit);
         wbrl_pkg::REG_IDLE_TMO:    prdata = 32'(cfg_ff.idle_tmo);
         default:                   prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/wbrl_rate.sv =====
// User and GC occupancy limits and rate state from the free user block count and the write-error line count.
module wbrl_rate #(
   parameter int BLOCK_COUNT_BITS = 20
) (
   input  logic [BLOCK_COUNT_BITS-1:0] free_user,
   input  logic [7:0]                  error_lines,
   input  wbrl_pkg::cfg_type           cfg,
   output wbrl_pkg::rate_type          rate
);

   localparam int CW = BLOCK_COUNT_BITS + 20;
   localparam int UW = BLOCK_COUNT_BITS + wbrl_pkg::REQ_WINDOW_LOG2 + 16;

   logic [CW-1:0]               f_wide;
   logic                        above_high;
   logic                        in_reserve;
   logic [4:0]                  shift;
   logic [BLOCK_COUNT_BITS-1:0] f_shr;
   logic [UW-1:0]               share;
   logic                        share_big;
   logic [15:0]                 user_low;
   logic [16:0]                 gc_win;
   logic [15:0]                 user_werr;

   assign f_wide     = CW'(free_user);
   assign above_high = f_wide >= CW'(cfg.high_thr);
   assign in_reserve = f_wide <= CW'(cfg.reserve);

   // Scale free blocks down to request windows; no negative shift
   assign shift = (cfg.high_log2 > {1'b0, cfg.win_log2}) ?
                  cfg.high_log2 - {1'b0, cfg.win_log2} : '0;
   assign f_shr     = free_user >> shift;
   assign share     = UW'(f_shr) << wbrl_pkg::REQ_WINDOW_LOG2;
   assign share_big = share > UW'(cfg.budget);
   assign user_low  = share_big ? cfg.budget : share[15:0];

   // Write-error recovery reserves one window set for GC
   assign gc_win    = 17'd1 << cfg.win_log2;
   assign user_werr = (17'(cfg.budget) > gc_win) ? 16'(17'(cfg.budget) - gc_win) : '0;

   always_comb begin
      if (above_high) begin
         if (error_lines != '0) begin
            rate.user_cap = user_werr;
            rate.gc_max   = gc_win[15:0];
            rate.state    = wbrl_pkg::RATE_WERR;
         end else begin
            rate.user_cap = cfg.budget;
            rate.gc_max   = '0;
            rate.state    = wbrl_pkg::RATE_OFF;
         end
      end else begin
         if (in_reserve) begin
            rate.user_cap = '0;
            rate.gc_max   = cfg.budget;
         end else begin
            rate.user_cap = user_low;
            rate.gc_max   = cfg.budget - user_low;
         end
         rate.state = wbrl_pkg::RATE_LOW;
      end
   end

endmodule

// ===== rtl/core/wbrl_state.sv =====
// Limiter state registers, event update and result word for one event.
module wbrl_state #(
   parameter int BLOCK_COUNT_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  wbrl_pkg::req_type      item,
   input  wbrl_pkg::cfg_type      cfg,
   input  wbrl_pkg::cfg_load_type load,
   output wbrl_pkg::rsp_type      result
);

   localparam int BW = BLOCK_COUNT_BITS;
   localparam int EW = BLOCK_COUNT_BITS + 17;
   localparam logic [BW-1:0] BLK_MAX = {BW{1'b1}};

   logic [15:0] uocc_ff, uocc_in;
   logic [15:0] gocc_ff, gocc_in;
   logic        space_unl_ff, space_unl_in;
   logic [15:0] space_ff, space_in;
   logic        active_ff, active_in;
   logic [15:0] idle_ff, idle_in;
   logic [7:0]  werr_ff, werr_in;
   logic [BW-1:0] ftot_ff, ftot_in;
   logic [BW-1:0] fuser_ff, fuser_in;
   logic [15:0] umax_ff, umax_in;
   logic [15:0] gmax_ff, gmax_in;
   wbrl_pkg::rate_state_type rstate_ff, rstate_in;

   logic [16:0]   user_sum;
   logic [16:0]   gc_sum;
   logic [EW-1:0] count_ext;
   logic [EW-1:0] ftot_sum;
   logic [EW-1:0] fuser_sum;
   logic [BW-1:0] ftot_add, ftot_sub;
   logic [BW-1:0] fuser_add, fuser_sub;
   logic [BW-1:0] fuser_nx;
   logic [BW+wbrl_pkg::FREE_OUT_BITS-1:0] fuser_out;
   logic [1:0]    verdict;
   wbrl_pkg::rate_type rate;

   // Saturating occupancy adds
   assign user_sum = {1'b0, uocc_ff} + {1'b0, item.count_a};
   assign gc_sum   = {1'b0, gocc_ff} + {1'b0, item.count_a};

   // Saturating block count adds and subtracts
   assign count_ext = EW'(item.count_a);
   assign ftot_sum  = EW'(ftot_ff) + count_ext;
   assign fuser_sum = EW'(fuser_ff) + count_ext;
   assign ftot_add  = (ftot_sum > EW'(BLK_MAX)) ? BLK_MAX : ftot_sum[BW-1:0];
   assign fuser_add = (fuser_sum > EW'(BLK_MAX)) ? BLK_MAX : fuser_sum[BW-1:0];
   assign ftot_sub  = (EW'(ftot_ff) > count_ext) ?
                      BW'(EW'(ftot_ff) - count_ext) : '0;
   assign fuser_sub = (EW'(fuser_ff) > count_ext) ?
                      BW'(EW'(fuser_ff) - count_ext) : '0;

   // Free user count after this event feeds the limit update
   always_comb begin
      if (item.kind == wbrl_pkg::KIND_LINE_FREED) begin
         fuser_nx = fuser_add;
      end else if (item.kind == wbrl_pkg::KIND_LINE_TAKEN && item.line_used) begin
         fuser_nx = fuser_sub;
      end else begin
         fuser_nx = fuser_ff;
      end
   end

   wbrl_rate #(
      .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
   ) u_rate (
      .free_user   (fuser_nx),
      .error_lines (werr_ff),
      .cfg         (cfg),
      .rate        (rate)
   );

   // Apply one event
   always_comb begin
      uocc_in      = uocc_ff;
      gocc_in      = gocc_ff;
      space_unl_in = space_unl_ff;
      space_in     = space_ff;
      active_in    = active_ff;
      idle_in      = idle_ff;
      werr_in      = werr_ff;
      ftot_in      = ftot_ff;
      fuser_in     = fuser_ff;
      umax_in      = umax_ff;
      gmax_in      = gmax_ff;
      rstate_in    = rstate_ff;
      verdict      = wbrl_pkg::VERDICT_OK;
      case (item.kind)
         wbrl_pkg::KIND_CHECK: begin
            if (!space_unl_ff && space_ff < item.count_a) begin
               verdict = wbrl_pkg::VERDICT_ERROR;
            end else if (uocc_ff >= umax_ff) begin
               verdict = wbrl_pkg::VERDICT_REQUEUE;
            end
         end
         wbrl_pkg::KIND_USER_IN: begin
            uocc_in   = user_sum[16] ? wbrl_pkg::CNT_MAX : user_sum[15:0];
            active_in = 1'b1;
            idle_in   = cfg.idle_tmo;
         end
         wbrl_pkg::KIND_GC_IN: begin
            gocc_in = gc_sum[16] ? wbrl_pkg::CNT_MAX : gc_sum[15:0];
         end
         wbrl_pkg::KIND_COMPLETE: begin
            uocc_in = (uocc_ff > item.count_a) ? uocc_ff - item.count_a : '0;
            gocc_in = (gocc_ff > item.count_b) ? gocc_ff - item.count_b : '0;
         end
         wbrl_pkg::KIND_INSERTED: begin
            // limited space floors at zero and never turns unlimited
            if (!space_unl_ff) begin
               space_in = (space_ff > item.count_a) ? space_ff - item.count_a : '0;
            end
         end
         wbrl_pkg::KIND_WERR_IN: begin
            if (werr_ff != wbrl_pkg::ERR_LINES_MAX) begin
               werr_in = werr_ff + 8'd1;
            end
         end
         wbrl_pkg::KIND_WERR_OUT: begin
            if (werr_ff != '0) begin
               werr_in = werr_ff - 8'd1;
            end
         end
         wbrl_pkg::KIND_LINE_FREED: begin
            ftot_in = ftot_add;
         end
         wbrl_pkg::KIND_LINE_TAKEN: begin
            ftot_in = ftot_sub;
         end
         wbrl_pkg::KIND_TICK: begin
            // a timeout of zero behaves as one
            if (active_ff) begin
               if (idle_ff <= 16'd1) begin
                  idle_in   = '0;
                  active_in = 1'b0;
               end else begin
                  idle_in = idle_ff - 16'd1;
               end
            end
         end
         default: ;
      endcase

      if (item.kind inside {wbrl_pkg::KIND_LINE_FREED, wbrl_pkg::KIND_LINE_TAKEN,
                            wbrl_pkg::KIND_RECOMPUTE}) begin
         fuser_in  = fuser_nx;
         umax_in   = rate.user_cap;
         gmax_in   = rate.gc_max;
         rstate_in = rate.state;
      end
   end

   // Status after the event
   assign fuser_out = {{wbrl_pkg::FREE_OUT_BITS{1'b0}}, fuser_in};

   always_comb begin
      result.user_verdict    = verdict;
      result.gc_allowed      = !(gocc_in >= gmax_in && active_in);
      result.buffer_full     = !space_unl_in && space_in == '0;
      result.rate_state      = rstate_in;
      result.user_limit      = umax_in;
      result.gc_limit        = gmax_in;
      result.gc_should_run   = rstate_in != wbrl_pkg::RATE_OFF;
      result.free_user_count = fuser_out[wbrl_pkg::FREE_OUT_BITS-1:0];
   end

   // Hold state; take events on fire, register loads when written
   always_ff @(posedge clock) begin
      if (reset) begin
         uocc_ff      <= '0;
         gocc_ff      <= '0;
         space_unl_ff <= 1'b1;
         space_ff     <= '0;
         active_ff    <= 1'b0;
         idle_ff      <= '0;
         werr_ff      <= '0;
         ftot_ff      <= '0;
         fuser_ff     <= '0;
         umax_ff      <= wbrl_pkg::BUDGET_RST;
         gmax_ff      <= '0;
         rstate_ff    <= wbrl_pkg::RATE_INIT;
      end else begin
         if (fire) begin
            uocc_ff   <= uocc_in;
            gocc_ff   <= gocc_in;
            active_ff <= active_in;
            idle_ff   <= idle_in;
            werr_ff   <= werr_in;
            ftot_ff   <= ftot_in;
            fuser_ff  <= fuser_in;
            gmax_ff   <= gmax_in;
            rstate_ff <= rstate_in;
         end
         // register loads take priority; the user must issue them only while idle, unchecked here
         if (load.space_load) begin
            space_unl_ff <= load.space_unl;
            space_ff     <= load.space_val;
         end else if (fire) begin
            space_unl_ff <= space_unl_in;
            space_ff     <= space_in;
         end
         if (load.budget_load && rstate_ff == wbrl_pkg::RATE_INIT) begin
            umax_ff <= load.budget_val;
         end else if (fire) begin
            umax_ff <= umax_in;
         end
      end
   end

endmodule

// ===== rtl/core/write_buffer_rate_limiter.sv =====
// Write buffer rate limiter top level: input register, event state, result register.
//
// Takes one event word per clock while results are taken and returns one status
// word per event. An accepted event sits in the input register while the limiter
// state update and its status word are worked out in one combinational pass; both
// are registered as the word advances, and while results are taken a new event can
// follow every cycle. A waiting result lets the input register take one more word;
// then the input stalls until the consumer takes the result, and in that same cycle
// it takes the next word. Registers sit behind an APB-style port at byte address
// 4*index; the user must see that they are written only while the block is idle,
// which the block does not enforce. Writing space_limit reloads the remaining
// space; a budget write before the first limit update also sets the user limit.
module write_buffer_rate_limiter #(
   parameter int BLOCK_COUNT_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wbrl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wbrl_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic                   in_valid_ff, in_valid_in;
   wbrl_pkg::req_type      in_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   wbrl_pkg::rsp_type      rsp_data_ff;
   wbrl_pkg::rsp_type      result;
   wbrl_pkg::cfg_type      cfg;
   wbrl_pkg::cfg_load_type load;
   logic                   advance;
   logic                   req_fire;

   wbrl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .load    (load)
   );

   // Process the held word when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   wbrl_state #(
      .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .load   (load),
      .result (result)
   );

   // Valid bits of the input and result registers
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A held word stays until processed
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input word lost while stalled");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // GC runs exactly when limiting is on
   a_gc_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.gc_should_run == (rsp_data.rate_state != wbrl_pkg::RATE_OFF))
      else $error("gc_should_run disagrees with rate state");

   // With limiting off GC gets no share
   a_off_gc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rate_state == wbrl_pkg::RATE_OFF |-> rsp_data.gc_limit == '0)
      else $error("nonzero GC limit with limiting off");
`endif

endmodule
